// ----- hw/rtl/dgtl_pkg.sv -----
// dgtl_pkg: shared types, register codes and reset values of the distance grid lookup
// no dependencies; imported by every module under hw/rtl
package dgtl_pkg;

	localparam int GRID_SIDE_DEF   = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [2:0] REG_CENTER_X   = 3'd0;
	localparam logic [2:0] REG_CENTER_Y   = 3'd1;
	localparam logic [2:0] REG_CENTER_Z   = 3'd2;
	localparam logic [2:0] REG_EXTENT_X   = 3'd3;
	localparam logic [2:0] REG_EXTENT_Y   = 3'd4;
	localparam logic [2:0] REG_EXTENT_Z   = 3'd5;
	localparam logic [2:0] REG_VOXELS     = 3'd6;
	localparam logic [2:0] REG_GRID_SCALE = 3'd7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic signed [31:0] CENTER_RST = 32'sd0;
	localparam logic [30:0]        EXTENT_RST = 31'd4194304;
	localparam logic [6:0]         VOXELS_RST = 7'd64;
	localparam logic [31:0]        SCALE_RST  = 32'd65536;

	typedef struct packed {
		logic               operation;
		logic [5:0]         voxel_x;
		logic [5:0]         voxel_y;
		logic [5:0]         voxel_z;
		logic signed [31:0] voxel_value;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
		logic signed [31:0] query_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] clearance;
		logic               valid_res;
	} out_item_t;

	typedef struct packed {
		logic [5:0]         x;
		logic [5:0]         y;
		logic [5:0]         z;
		logic signed [31:0] value;
	} wr_item_t;

	// load enables of the pipeline registers
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic so;
	} pipe_en_t;

endpackage

// ----- hw/rtl/dgtl_axis.sv -----
// dgtl_axis: per-axis front end, box test, scaling to voxel coordinates, grid bounds check
// depends on dgtl_pkg; four register stages s1 to s4
module dgtl_axis import dgtl_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF,
	localparam int CW = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1
) (
	input  logic               clk,
	input  pipe_en_t           en,
	input  logic signed [31:0] q,
	input  logic signed [31:0] c,
	input  logic [30:0]        e,
	input  logic [31:0]        scale,
	input  logic [6:0]         vpa,
	output logic [CW-1:0]      lo,
	output logic               nz,
	output logic [16:0]        w,
	output logic               ok
);

	localparam int LW = $clog2(GRID_SIDE + 1);

	logic signed [34:0] q2, c2, lo_b, hi_b;
	logic signed [32:0] d_s1;
	logic               in_s1, in_s2, in_s3;
	logic signed [49:0] plo_s2, phi_s2;
	logic signed [67:0] v_s3;
	logic [35:0]        fl;
	logic [31:0]        fr;
	logic [36:0]        ce;
	logic [LW-1:0]      lim;
	logic [CW-1:0]      lo_s4;
	logic               nz_s4, ok_s4;
	logic [16:0]        w_s4;

	assign q2   = 35'(q) <<< 1;
	assign c2   = 35'(c) <<< 1;
	assign lo_b = c2 - $signed({4'd0, e});
	assign hi_b = c2 + $signed({4'd0, e});

	always_ff @(posedge clk) begin
		if (en.s1) begin
			d_s1  <= 33'(q) - 33'(c);
			in_s1 <= !(q2 < lo_b || q2 > hi_b);
		end
		if (en.s2) begin
			plo_s2 <= d_s1 * $signed({1'b0, scale[15:0]});
			phi_s2 <= d_s1 * $signed({1'b0, scale[31:16]});
			in_s2  <= in_s1;
		end
		if (en.s3) begin
			v_s3  <= 68'(plo_s2) + (68'(phi_s2) <<< 16) + $signed(68'(vpa) << 31);
			in_s3 <= in_s2;
		end
	end

	assign fl  = v_s3[67:32];
	assign fr  = v_s3[31:0];
	assign ce  = 37'(fl) + 37'(|fr);
	assign lim = ({25'd0, vpa} < 32'(GRID_SIDE)) ? LW'(vpa) : LW'(GRID_SIDE);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			lo_s4 <= fl[CW-1:0];
			nz_s4 <= |fr;
			w_s4  <= 17'(({1'b0, fr} + 33'h8000) >> 16);
			ok_s4 <= in_s3 && !v_s3[67] && (ce < 37'(lim));
		end
	end

	assign lo = lo_s4;
	assign nz = nz_s4;
	assign w  = w_s4;
	assign ok = ok_s4;

endmodule

// ----- hw/rtl/dgtl_grid_mem.sv -----
// dgtl_grid_mem: voxel store split into eight banks by coordinate parity
// depends on dgtl_pkg; one write to one bank and one registered read per bank per enabled cycle
module dgtl_grid_mem import dgtl_pkg::*; #(
	parameter int GRID_SIDE   = GRID_SIDE_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int CW = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1,
	localparam int HW = (CW > 1) ? CW - 1 : 1,
	localparam int AW = 3 * HW
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr [8],
	input  logic               wr_en,
	input  logic [2:0]         wr_bank,
	input  logic [AW-1:0]      wr_addr,
	input  logic signed [31:0] wr_data,
	output logic signed [31:0] rd_data [8]
);

	localparam int DEPTH = 1 << AW;

	logic [VALUE_WIDTH-1:0] wr_word;

	generate
		if (VALUE_WIDTH <= 32) begin : g_wnarrow
			assign wr_word = wr_data[VALUE_WIDTH-1:0];
		end else begin : g_wwide
			assign wr_word = {{(VALUE_WIDTH - 32){wr_data[31]}}, wr_data};
		end
	endgenerate

	for (genvar b = 0; b < 8; b++) begin : g_bank
		logic [VALUE_WIDTH-1:0] mem [DEPTH];
		logic [VALUE_WIDTH-1:0] rq;

		always_ff @(posedge clk) begin
			if (wr_en && wr_bank == 3'(b)) begin
				mem[wr_addr] <= wr_word;
			end
			if (rd_en) begin
				rq <= mem[rd_addr[b]];
			end
		end

		if (VALUE_WIDTH < 32) begin : g_rnarrow
			assign rd_data[b] = {{(32 - VALUE_WIDTH){rq[VALUE_WIDTH-1]}}, rq};
		end else begin : g_rwide
			assign rd_data[b] = rq[31:0];
		end
	end

endmodule

// ----- hw/rtl/dgtl_blend.sv -----
// dgtl_blend: corner selection and trilinear blend, x then y then z
// depends on dgtl_pkg; stages s5 to the output register
module dgtl_blend import dgtl_pkg::*; (
	input  logic               clk,
	input  pipe_en_t           en,
	input  logic signed [31:0] rd_data [8],
	input  logic               ok,
	input  logic [2:0]         par,
	input  logic [2:0]         nz,
	input  logic [16:0]        wx,
	input  logic [16:0]        wy,
	input  logic [16:0]        wz,
	output out_item_t          out_data
);

	function automatic logic signed [31:0] lerp(logic signed [31:0] a, logic signed [31:0] b,
		logic [16:0] wt);
		logic signed [32:0] dd;
		logic signed [50:0] p;
		dd = 33'(b) - 33'(a);
		p  = dd * $signed({1'b0, wt});
		p  = p + 51'sd32768;
		return 32'(33'(a) + 33'(p >>> 16));
	endfunction

	logic               ok_s5, ok_s6, ok_s7;
	logic [2:0]         par_s5, nz_s5;
	logic [16:0]        wx_s5, wy_s5, wz_s5, wy_s6, wz_s6, wz_s7;
	logic signed [31:0] ca [4];
	logic signed [31:0] cb [4];
	logic signed [31:0] cx_s6 [4];
	logic signed [31:0] cy_s7 [2];
	logic signed [31:0] r;
	out_item_t          out_so;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			ok_s5  <= ok;
			par_s5 <= par;
			nz_s5  <= nz;
			wx_s5  <= wx;
			wy_s5  <= wy;
			wz_s5  <= wz;
		end
	end

	// a flat axis reads its low corner twice
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic       jy, jz;
			logic [2:0] ia, ib;
			jy = 1'(k >> 1);
			jz = 1'(k);
			ia = {par_s5[2], par_s5[1] ^ (jy & nz_s5[1]), par_s5[0] ^ (jz & nz_s5[0])};
			ib = {par_s5[2] ^ nz_s5[2], ia[1:0]};
			ca[k] = rd_data[ia];
			cb[k] = rd_data[ib];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			for (int k = 0; k < 4; k++) begin
				cx_s6[k] <= lerp(ca[k], cb[k], wx_s5);
			end
			wy_s6 <= wy_s5;
			wz_s6 <= wz_s5;
			ok_s6 <= ok_s5;
		end
		if (en.s7) begin
			cy_s7[0] <= lerp(cx_s6[0], cx_s6[2], wy_s6);
			cy_s7[1] <= lerp(cx_s6[1], cx_s6[3], wy_s6);
			wz_s7    <= wz_s6;
			ok_s7    <= ok_s6;
		end
		if (en.so) begin
			out_so.clearance <= ok_s7 ? r : 32'sd0;
			out_so.valid_res <= ok_s7;
		end
	end

	assign r        = lerp(cy_s7[0], cy_s7[1], wz_s7);
	assign out_data = out_so;

endmodule

// ----- hw/rtl/distance_grid_trilinear_lookup_top.sv -----
// distance_grid_trilinear_lookup_top: top level of the voxel distance grid lookup
// depends on dgtl_pkg, dgtl_axis, dgtl_grid_mem, dgtl_blend
//
// Input channel in_valid/in_stall/in_data carries write items (operation 0),
// which store one voxel (when inside the grid) and give no result, and query items (operation 1),
// which give one result on out_valid/out_stall/out_data.
// A transfer happens on a rising edge with valid high and stall low.
// Configuration registers are written through cfg_valid/cfg_ready/cfg_index/
// cfg_data; cfg_ready is always high. Write them only while the block is idle.
// A query passes through register stages s1 to s7 and the output register.
// Throughput is one item per cycle while out_stall is low; the grid sits in
// eight parity banks so the eight corners of a query are read in the same cycle.
// Stalls back up stage by stage; empty stages keep filling, so in_stall rises
// only once every stage holds an item. Nothing is lost or repeated.
// Reset clears the pipeline and loads the configuration defaults; grid
// contents are undefined until written.
module distance_grid_trilinear_lookup_top import dgtl_pkg::*; #(
	parameter int GRID_SIDE   = GRID_SIDE_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW  = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1;
	localparam int CW1 = CW + 1;
	localparam int HW  = (CW > 1) ? CW - 1 : 1;
	localparam int AW  = 3 * HW;

	logic signed [31:0] center_q [3];
	logic [30:0]        extent_q [3];
	logic [6:0]         vpa_q;
	logic [31:0]        scale_q;

	pipe_en_t           en;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, out_vld_q;
	logic               op_s1, op_s2, op_s3, op_s4;
	wr_item_t           wr_s1, wr_s2, wr_s3, wr_s4;

	logic signed [31:0] qv [3];
	logic [CW-1:0]      lo [3];
	logic [2:0]         nz, ok, par;
	logic [16:0]        w [3];

	logic [AW-1:0]      rd_addr [8];
	logic signed [31:0] rd_data [8];
	logic               wr_en;
	logic [AW-1:0]      wr_addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				center_q[a] <= CENTER_RST;
				extent_q[a] <= EXTENT_RST;
			end
			vpa_q   <= VOXELS_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X:   center_q[0] <= cfg_data;
				REG_CENTER_Y:   center_q[1] <= cfg_data;
				REG_CENTER_Z:   center_q[2] <= cfg_data;
				REG_EXTENT_X:   extent_q[0] <= cfg_data[30:0];
				REG_EXTENT_Y:   extent_q[1] <= cfg_data[30:0];
				REG_EXTENT_Z:   extent_q[2] <= cfg_data[30:0];
				REG_VOXELS:     vpa_q       <= cfg_data[6:0];
				REG_GRID_SCALE: scale_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when empty or when its content moves on
	assign en.so    = !out_vld_q || !out_stall;
	assign en.s7    = !v_s7 || en.so;
	assign en.s6    = !v_s6 || en.s7;
	assign en.s5    = !v_s5 || en.s6;
	assign en.s4    = !v_s4 || en.s5;
	assign en.s3    = !v_s3 || en.s4;
	assign en.s2    = !v_s2 || en.s3;
	assign en.s1    = !v_s1 || en.s2;
	assign in_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4 && (op_s4 == OP_QUERY);
			if (en.s6) v_s6 <= v_s5;
			if (en.s7) v_s7 <= v_s6;
			if (en.so) out_vld_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1 <= in_data.operation;
			wr_s1 <= '{x: in_data.voxel_x, y: in_data.voxel_y, z: in_data.voxel_z,
				value: in_data.voxel_value};
		end
		if (en.s2) begin
			op_s2 <= op_s1;
			wr_s2 <= wr_s1;
		end
		if (en.s3) begin
			op_s3 <= op_s2;
			wr_s3 <= wr_s2;
		end
		if (en.s4) begin
			op_s4 <= op_s3;
			wr_s4 <= wr_s3;
		end
	end

	assign qv[0] = in_data.query_x;
	assign qv[1] = in_data.query_y;
	assign qv[2] = in_data.query_z;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		dgtl_axis #(.GRID_SIDE(GRID_SIDE)) u_axis (
			.clk   (clk),
			.en    (en),
			.q     (qv[a]),
			.c     (center_q[a]),
			.e     (extent_q[a]),
			.scale (scale_q),
			.vpa   (vpa_q),
			.lo    (lo[a]),
			.nz    (nz[2-a]),
			.w     (w[a]),
			.ok    (ok[a])
		);
		assign par[2-a] = lo[a][0];
	end

	// each bank reads the corner coordinate of its own parity
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			logic           p;
			logic [CW1-1:0] cp;
			logic [HW-1:0]  hf [3];
			for (int a = 0; a < 3; a++) begin
				p     = 1'(b >> (2 - a));
				cp    = {1'b0, lo[a]} + CW1'(lo[a][0] != p);
				hf[a] = HW'(cp >> 1);
			end
			rd_addr[b] = {hf[0], hf[1], hf[2]};
		end
	end

	assign wr_en = v_s4 && (op_s4 == OP_WRITE) && en.s5 &&
		(32'(wr_s4.x) < 32'(GRID_SIDE)) && (32'(wr_s4.y) < 32'(GRID_SIDE)) &&
		(32'(wr_s4.z) < 32'(GRID_SIDE));
	assign wr_addr = {HW'(wr_s4.x >> 1), HW'(wr_s4.y >> 1), HW'(wr_s4.z >> 1)};

	dgtl_grid_mem #(.GRID_SIDE(GRID_SIDE), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
		.clk     (clk),
		.rd_en   (en.s5),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_bank ({wr_s4.x[0], wr_s4.y[0], wr_s4.z[0]}),
		.wr_addr (wr_addr),
		.wr_data (wr_s4.value),
		.rd_data (rd_data)
	);

	dgtl_blend u_blend (
		.clk      (clk),
		.en       (en),
		.rd_data  (rd_data),
		.ok       (&ok),
		.par      (par),
		.nz       (nz),
		.wx       (w[0]),
		.wy       (w[1]),
		.wz       (w[2]),
		.out_data (out_data)
	);

	assign out_valid = out_vld_q;

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall) else $error("input stalled with empty first stage");
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall) else $error("input stalled while output drains");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.valid_res) |-> (out_data.clearance == 32'sd0))
		else $error("invalid result with nonzero clearance");

endmodule
